/* rtl/core/mrgm_pkg.sv */
package mrgm_pkg;

  localparam int PixW  = 64;
  localparam int AvgW  = 16;
  localparam int IdxW  = 3;
  localparam int CntW  = IdxW + 1;
  localparam int DevW  = 17;
  localparam int ProdW = 2 * DevW;
  localparam int AccW  = 50;

  localparam logic [CntW-1:0] NumObjectsReset = 4'd8;

  localparam logic signed [AccW-1:0] SatHi = 50'sh1_0000_0000_0000;
  localparam logic signed [AccW-1:0] SatLo = -SatHi;

  typedef struct packed {
    logic            valid;
    logic            last;
    logic [CntW-1:0] count;
  } prod_ctl_t;

  typedef struct packed {
    logic start;
    logic busy;
  } emit_stat_t;

endpackage

/* rtl/core/mrgm_prod.sv */
module mrgm_prod #(
  parameter int MaxObjects = 8,
  localparam int NumPairs = MaxObjects * (MaxObjects + 1) / 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  take_i,
  input  logic [mrgm_pkg::PixW-1:0]             pixels_i,
  input  logic [mrgm_pkg::AvgW-1:0]             average_i,
  input  logic                                  last_i,
  input  logic [mrgm_pkg::CntW-1:0]             count_i,
  output mrgm_pkg::prod_ctl_t                   ctl_o,
  output logic signed [mrgm_pkg::ProdW-1:0]     prod_o [NumPairs]
);
  import mrgm_pkg::*;

  logic            v1_q;
  logic            last1_q;
  logic [CntW-1:0] cnt1_q;
  logic [PixW-1:0] pix1_q;
  logic [AvgW-1:0] avg1_q;

  prod_ctl_t                ctl_q;
  logic signed [DevW-1:0]   dev  [MaxObjects];
  logic signed [ProdW-1:0]  prod_d [NumPairs];
  logic signed [ProdW-1:0]  prod_q [NumPairs];

  always_comb begin
    int p;
    p = 0;
    for (int k = 0; k < MaxObjects; k++) begin
      dev[k] = $signed({1'b0, pix1_q[8*k +: 8], 8'h00}) - $signed({1'b0, avg1_q});
    end
    for (int i = 0; i < MaxObjects; i++) begin
      for (int j = i; j < MaxObjects; j++) begin
        if (CntW'(j) < cnt1_q) begin
          prod_d[p] = dev[i] * dev[j];
        end else begin
          prod_d[p] = '0;
        end
        p++;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      ctl_q <= '0;
    end else begin
      v1_q        <= take_i;
      ctl_q.valid <= v1_q;
      ctl_q.last  <= last1_q;
      ctl_q.count <= cnt1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      last1_q <= last_i;
      cnt1_q  <= count_i;
      pix1_q  <= pixels_i;
      avg1_q  <= average_i;
    end
    if (v1_q) begin
      prod_q <= prod_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign prod_o = prod_q;

endmodule

/* rtl/core/mrgm_acc.sv */
module mrgm_acc #(
  parameter int MaxObjects = 8,
  localparam int NumPairs = MaxObjects * (MaxObjects + 1) / 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mrgm_pkg::prod_ctl_t                   ctl_i,
  input  logic signed [mrgm_pkg::ProdW-1:0]     prod_i [NumPairs],
  output mrgm_pkg::emit_stat_t                  stat_o,
  output logic                                  valid_o,
  input  logic                                  ready_i,
  output logic [mrgm_pkg::IdxW-1:0]             row_o,
  output logic [mrgm_pkg::IdxW-1:0]             col_o,
  output logic signed [mrgm_pkg::AccW-1:0]      value_o,
  output logic                                  last_o
);
  import mrgm_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxObjects - 1);

  logic signed [AccW-1:0] acc_q [NumPairs];
  logic signed [AccW:0]   sum   [NumPairs];
  logic signed [AccW-1:0] sat_v [NumPairs];

  logic            emit_q;
  logic [IdxW-1:0] wi_q;
  logic [IdxW-1:0] wj_q;
  logic [CntW-1:0] cnt_q;
  logic            out_valid_q;
  logic [IdxW-1:0] out_row_q;
  logic [IdxW-1:0] out_col_q;
  logic signed [AccW-1:0] out_val_q;
  logic            out_last_q;

  logic step;
  logic at_end;
  logic in_range;
  logic is_final;

  always_comb begin
    for (int p = 0; p < NumPairs; p++) begin
      sum[p] = (AccW+1)'(acc_q[p]) + (AccW+1)'(prod_i[p]);
      if (sum[p] > SatHi) begin
        sat_v[p] = SatHi;
      end else if (sum[p] < SatLo) begin
        sat_v[p] = SatLo;
      end else begin
        sat_v[p] = sum[p][AccW-1:0];
      end
    end
  end

  assign step     = emit_q && (!out_valid_q || ready_i);
  assign at_end   = (wi_q == LastIdx) && (wj_q == LastIdx);
  assign in_range = {1'b0, wj_q} < cnt_q;
  assign is_final = ({1'b0, wi_q} == cnt_q - 1'b1) && ({1'b0, wj_q} == cnt_q - 1'b1);

  // add products, or shift triangle out via entry 0; zeros fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumPairs; p++) begin
        acc_q[p] <= '0;
      end
    end else if (step) begin
      for (int p = 0; p < NumPairs - 1; p++) begin
        acc_q[p] <= acc_q[p+1];
      end
      acc_q[NumPairs-1] <= '0;
    end else if (ctl_i.valid) begin
      acc_q <= sat_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_q      <= 1'b0;
      wi_q        <= '0;
      wj_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (ctl_i.valid && ctl_i.last) begin
      emit_q <= 1'b1;
      cnt_q  <= ctl_i.count;
      wi_q   <= '0;
      wj_q   <= '0;
    end else if (step) begin
      out_valid_q <= in_range;
      if (at_end) begin
        emit_q <= 1'b0;
      end else if (wj_q == LastIdx) begin
        wi_q <= wi_q + 1'b1;
        wj_q <= wi_q + 1'b1;
      end else begin
        wj_q <= wj_q + 1'b1;
      end
    end else if (out_valid_q && ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_row_q  <= wi_q;
      out_col_q  <= wj_q;
      out_val_q  <= acc_q[0];
      out_last_q <= is_final;
    end
  end

  assign stat_o.start = ctl_i.valid && ctl_i.last;
  assign stat_o.busy  = emit_q || out_valid_q;
  assign valid_o      = out_valid_q;
  assign row_o        = out_row_q;
  assign col_o        = out_col_q;
  assign value_o      = out_val_q;
  assign last_o       = out_last_q;

  a_no_acc_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_q || out_valid_q) |-> !ctl_i.valid)
    else $error("accumulate during emission");

  a_upper_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_col_q >= out_row_q))
    else $error("entry below diagonal");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_val_q <= SatHi) && (out_val_q >= SatLo)))
    else $error("value outside saturation range");

endmodule

/* rtl/core/mean_removed_gram_matrix.sv */
// channel   dir  tdata                                         tuser  tlast
// s_axis    in   pixels[63:0] average[79:64]                   -      last_pixel
// m_axis    out  row[2:0] col[5:3] value[55:6]                 -      last_entry
// cfg       in   num_objects[3:0]                              -      -
//
// One pixel per cycle while tready is high; pixels pass input and product registers.
// A last pixel stops input until its matrix is out: the emission walks all
// MAX_OBJECTS*(MAX_OBJECTS+1)/2 accumulator slots, one per cycle plus output stalls.
// Output stalls hold the emission walk; input stalls only idle the pipeline.
// Reset clears all accumulators at once and sets num_objects to 8.
module mean_removed_gram_matrix #(
  parameter int MAX_OBJECTS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [3:0]                cfg_wdata_i,    // num_objects
  input  logic                      s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  logic [79:0]               s_axis_tdata_i, // pixels, average
  input  logic                      s_axis_tlast_i,
  output logic                      m_axis_tvalid_o,
  input  logic                      m_axis_tready_i,
  output logic [55:0]               m_axis_tdata_o, // row, col, value
  output logic                      m_axis_tlast_o
);
  import mrgm_pkg::*;

  localparam int NumPairs = MAX_OBJECTS * (MAX_OBJECTS + 1) / 2;

  logic [CntW-1:0] num_q;
  logic [CntW-1:0] eff_cnt;
  logic            hold_q;
  logic            take;

  prod_ctl_t              ctl;
  emit_stat_t             stat;
  logic signed [ProdW-1:0] prod [NumPairs];
  logic [IdxW-1:0]        row;
  logic [IdxW-1:0]        col;
  logic signed [AccW-1:0] value;

  always_comb begin
    if (num_q == '0) begin
      eff_cnt = CntW'(1);
    end else if (num_q > CntW'(MAX_OBJECTS)) begin
      eff_cnt = CntW'(MAX_OBJECTS);
    end else begin
      eff_cnt = num_q;
    end
  end

  assign s_axis_tready_o = !hold_q && !stat.busy;
  assign take            = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= NumObjectsReset;
      hold_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_q <= cfg_wdata_i;
      end
      if (take && s_axis_tlast_i) begin
        hold_q <= 1'b1;
      end else if (stat.start) begin
        hold_q <= 1'b0;
      end
    end
  end

  mrgm_prod #(
    .MaxObjects(MAX_OBJECTS)
  ) u_prod (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .pixels_i (s_axis_tdata_i[PixW-1:0]),
    .average_i(s_axis_tdata_i[PixW+AvgW-1:PixW]),
    .last_i   (s_axis_tlast_i),
    .count_i  (eff_cnt),
    .ctl_o    (ctl),
    .prod_o   (prod)
  );

  mrgm_acc #(
    .MaxObjects(MAX_OBJECTS)
  ) u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .prod_i (prod),
    .stat_o (stat),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .row_o  (row),
    .col_o  (col),
    .value_o(value),
    .last_o (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {value, col, row};

endmodule
